[rtl/fwr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwr_pkg
// Shared types and constants of the 2-D full-weighting restriction block.
// ----------------------------------------------------------------------------
package fwr_pkg;

    // Default build sizes
    localparam int MAX_COARSE_COLS_DEF = 512;
    localparam int SAMPLE_BITS_DEF     = 32;

    // Field widths
    localparam int COARSE_COLS_W = 10;
    localparam int COARSE_ROWS_W = 15;
    localparam int WEIGHT_W      = 16;
    localparam int VALUE_W       = 32;
    localparam int FINE_ROW_W    = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COARSE_COLS = 2'd0,
        REG_COARSE_ROWS = 2'd1,
        REG_WEIGHT      = 2'd2
    } reg_index_t;

    localparam logic [COARSE_COLS_W-1:0] COARSE_COLS_RST = 10'd512;
    localparam logic [COARSE_ROWS_W-1:0] COARSE_ROWS_RST = 15'd512;
    localparam logic [WEIGHT_W-1:0]      WEIGHT_RST      = 16'd16384;

    // Stencil sum times Q2.14 weight, divided by 16: 2^4 * 2^14
    localparam int FRAC_BITS = 18;

    // Result queue
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_FIFO_PTR_W = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_FIFO_CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int PEND_W         = 3;

    // Where a coarse value comes from
    typedef enum logic [1:0] {
        KIND_COPY_CUR,
        KIND_COPY_PREV,
        KIND_INTERIOR
    } kind_t;

    // Per-sample control travelling down the pipeline
    typedef struct packed {
        logic                     emit;
        kind_t                    kind;
        logic [COARSE_COLS_W-1:0] col;
        logic [COARSE_ROWS_W-1:0] row;
        logic                     last;
    } ctrl_t;

    // One result word
    typedef struct packed {
        logic [VALUE_W-1:0]       value;
        logic [COARSE_COLS_W-1:0] col;
        logic [COARSE_ROWS_W-1:0] row;
        logic                     last;
    } result_t;

endpackage

[rtl/full_weighting_restriction_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// full_weighting_restriction_2d
// Multigrid full-weighting restriction of a raster fine grid to its coarse
// grid, with line memories and a 3x3 sliding window.
// ----------------------------------------------------------------------------
// Channel | Direction | Word
// s_      | in        | one fine sample, raster order
// m_      | out       | one coarse point: value, column, row, last flag
//
// One fine sample per cycle while s_ready is high; the line memory read/write-back and
// the window advance on every accepted sample.
// A result passes the read stage, four arithmetic stages and the result
// queue after the sample that completes it.
// After reset a sweep over all 2*MAX_COARSE_COLS+1 entries zeroes the line
// memories; s_ready stays low during it. Configuration writes are taken.
// An 8-word result queue with credit counting holds results under output
// stalls; after the sweep s_ready drops only when the queue could overflow.
// ----------------------------------------------------------------------------
module full_weighting_restriction_2d #(
    parameter int MAX_COARSE_COLS = fwr_pkg::MAX_COARSE_COLS_DEF,
    parameter int SAMPLE_BITS     = fwr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration
    input  logic                                cfg_wr_en,
    input  logic [fwr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fwr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Fine samples
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    // Coarse points
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fwr_pkg::VALUE_W-1:0]  m_coarse_value,
    output logic [fwr_pkg::COARSE_COLS_W-1:0]   m_coarse_col,
    output logic [fwr_pkg::COARSE_ROWS_W-1:0]   m_coarse_row,
    output logic                                m_grid_last
);

    localparam int LINE_DEPTH = 2 * MAX_COARSE_COLS + 1;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int RW         = fwr_pkg::FINE_ROW_W;

    // Configuration registers
    logic [fwr_pkg::COARSE_COLS_W-1:0] coarse_cols_reg;
    logic [fwr_pkg::COARSE_ROWS_W-1:0] coarse_rows_reg;
    logic [fwr_pkg::WEIGHT_W-1:0]      weight_reg;

    // Fine position
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0]    row_cnt_reg, row_cnt_next;

    // Stage 1
    logic                          s1_valid_reg;
    logic [COL_W-1:0]              s1_addr_reg;
    logic signed [SAMPLE_BITS-1:0] s1_cur_reg;
    fwr_pkg::ctrl_t                s1_ctrl_reg;

    logic                            accept;
    logic [COL_W-1:0]                cc_eff, two_cc;
    logic [fwr_pkg::COARSE_ROWS_W-1:0] cr_eff;
    logic [RW-1:0]                   two_cr;
    fwr_pkg::ctrl_t                  ctrl_s0;
    logic signed [SAMPLE_BITS-1:0]   line_prev, line_prev2;
    logic                            clr_busy;
    logic                            st_valid;
    fwr_pkg::result_t                st_result, q_data;
    logic [fwr_pkg::PEND_W-1:0]      st_pend;
    logic [fwr_pkg::OUT_FIFO_CNT_W-1:0] q_count;
    logic [fwr_pkg::OUT_FIFO_CNT_W:0]   occupancy;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coarse_cols_reg <= fwr_pkg::COARSE_COLS_RST;
            coarse_rows_reg <= fwr_pkg::COARSE_ROWS_RST;
            weight_reg      <= fwr_pkg::WEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fwr_pkg::REG_COARSE_COLS:
                    coarse_cols_reg <= cfg_data[fwr_pkg::COARSE_COLS_W-1:0];
                fwr_pkg::REG_COARSE_ROWS:
                    coarse_rows_reg <= cfg_data[fwr_pkg::COARSE_ROWS_W-1:0];
                fwr_pkg::REG_WEIGHT:
                    weight_reg      <= cfg_data[fwr_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, columns capped at the line length
    always_comb begin
        if (coarse_cols_reg == '0) begin
            cc_eff = COL_W'(1);
        end else if (32'(coarse_cols_reg) > 32'(MAX_COARSE_COLS)) begin
            cc_eff = COL_W'(MAX_COARSE_COLS);
        end else begin
            cc_eff = COL_W'(coarse_cols_reg);
        end
        two_cc = cc_eff << 1;
        cr_eff = (coarse_rows_reg == '0) ? fwr_pkg::COARSE_ROWS_W'(1) : coarse_rows_reg;
        two_cr = {cr_eff, 1'b0};
    end

    // Which coarse point, if any, this sample completes
    always_comb begin
        ctrl_s0      = '0;
        ctrl_s0.kind = fwr_pkg::KIND_COPY_CUR;
        ctrl_s0.col  = fwr_pkg::COARSE_COLS_W'(col_cnt_reg >> 1);
        ctrl_s0.row  = fwr_pkg::COARSE_ROWS_W'(row_cnt_reg >> 1);
        ctrl_s0.last = (row_cnt_reg == two_cr) && (col_cnt_reg == two_cc);
        if (col_cnt_reg <= two_cc && row_cnt_reg <= two_cr) begin
            if ((row_cnt_reg == '0 || row_cnt_reg == two_cr) && !col_cnt_reg[0]) begin
                // top or bottom border row
                ctrl_s0.emit = 1'b1;
            end else if (row_cnt_reg[0] && row_cnt_reg >= RW'(3)
                         && row_cnt_reg <= two_cr - 1'b1) begin
                if (col_cnt_reg == '0 || col_cnt_reg == two_cc) begin
                    // left or right border of an interior row
                    ctrl_s0.emit = 1'b1;
                    ctrl_s0.kind = fwr_pkg::KIND_COPY_PREV;
                end else if (col_cnt_reg[0] && col_cnt_reg >= COL_W'(3)) begin
                    ctrl_s0.emit = 1'b1;
                    ctrl_s0.kind = fwr_pkg::KIND_INTERIOR;
                end
            end
        end
    end

    // Raster counters
    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (col_cnt_reg >= two_cc) begin
            col_cnt_next = '0;
            row_cnt_next = (row_cnt_reg >= two_cr) ? '0 : row_cnt_reg + 1'b1;
        end else begin
            col_cnt_next = col_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg <= col_cnt_reg;
            s1_cur_reg  <= s_sample;
            s1_ctrl_reg <= ctrl_s0;
        end
    end

    // Credit: queue words plus results still in the pipeline
    assign occupancy = (fwr_pkg::OUT_FIFO_CNT_W + 1)'(q_count)
                     + (fwr_pkg::OUT_FIFO_CNT_W + 1)'(st_pend)
                     + (fwr_pkg::OUT_FIFO_CNT_W + 1)'(s1_valid_reg && s1_ctrl_reg.emit);
    assign s_ready   = !clr_busy
                     && (occupancy < (fwr_pkg::OUT_FIFO_CNT_W + 1)'(fwr_pkg::OUT_FIFO_DEPTH));
    assign accept    = s_valid && s_ready;

    // Same column is revisited at least three samples later, so the
    // write-back always lands before the next read of that entry.
    fwr_line_buf #(
        .DEPTH       (LINE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (col_cnt_reg),
        .wr_en    (s1_valid_reg),
        .wr_addr  (s1_addr_reg),
        .wr_data  (s1_cur_reg),
        .rd_prev  (line_prev),
        .rd_prev2 (line_prev2),
        .busy     (clr_busy)
    );

    fwr_stencil #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_stencil (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s1_valid_reg),
        .in_ctrl    (s1_ctrl_reg),
        .in_cur     (s1_cur_reg),
        .in_prev    (line_prev),
        .in_prev2   (line_prev2),
        .weight     (weight_reg),
        .out_valid  (st_valid),
        .out_result (st_result),
        .pend_count (st_pend)
    );

    fwr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (st_valid),
        .push_data (st_result),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign m_coarse_value = q_data.value;
    assign m_coarse_col   = q_data.col;
    assign m_coarse_row   = q_data.row;
    assign m_grid_last    = q_data.last;

endmodule

[rtl/fwr_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwr_line_buf
// Two fine-row line memories, read at accept and written back in the next
// cycle; cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module fwr_line_buf #(
    parameter int DEPTH       = 2 * fwr_pkg::MAX_COARSE_COLS_DEF + 1,
    parameter int SAMPLE_BITS = fwr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    output logic signed [SAMPLE_BITS-1:0] rd_prev,
    output logic signed [SAMPLE_BITS-1:0] rd_prev2,
    output logic                          busy
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic signed [SAMPLE_BITS-1:0] mem_prev  [DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_prev2 [DEPTH];

    logic                          clr_busy_reg;
    logic [ADDR_W-1:0]             clr_addr_reg;
    logic signed [SAMPLE_BITS-1:0] rd_prev_reg;
    logic signed [SAMPLE_BITS-1:0] rd_prev2_reg;

    // Clearing sweep, one entry of each memory per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write port: the current row goes to prev, what prev held moves to prev2
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem_prev[clr_addr_reg]  <= '0;
            mem_prev2[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem_prev[wr_addr]  <= wr_data;
            mem_prev2[wr_addr] <= rd_prev_reg;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_prev_reg  <= mem_prev[rd_addr];
            rd_prev2_reg <= mem_prev2[rd_addr];
        end
    end

    assign rd_prev  = rd_prev_reg;
    assign rd_prev2 = rd_prev2_reg;
    assign busy     = clr_busy_reg;

endmodule

[rtl/fwr_stencil.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwr_stencil
// Sliding 3x3 window and the weighting pipeline: partial sums, stencil sum,
// split multiply by the weight, round, saturate and format.
// ----------------------------------------------------------------------------
module fwr_stencil #(
    parameter int SAMPLE_BITS = fwr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  fwr_pkg::ctrl_t                  in_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]   in_cur,
    input  logic signed [SAMPLE_BITS-1:0]   in_prev,
    input  logic signed [SAMPLE_BITS-1:0]   in_prev2,
    input  logic [fwr_pkg::WEIGHT_W-1:0]    weight,
    output logic                            out_valid,
    output fwr_pkg::result_t                out_result,
    output logic [fwr_pkg::PEND_W-1:0]      pend_count
);

    localparam int SB        = SAMPLE_BITS;
    localparam int FB        = fwr_pkg::FRAC_BITS;
    localparam int SUM_W     = SB + 4;
    localparam int EXT_W     = (SUM_W > FB + 2) ? SUM_W : FB + 2;
    localparam int HI_W      = EXT_W - FB;
    localparam int PROD_HI_W = HI_W + fwr_pkg::WEIGHT_W + 1;
    localparam int PROD_LO_W = FB + fwr_pkg::WEIGHT_W + 1;
    localparam int FRAC_W    = PROD_LO_W - FB;
    localparam int RES_W     = PROD_HI_W + 1;
    localparam int VW        = fwr_pkg::VALUE_W;

    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'({1'b0, {(SB - 1){1'b1}}});
    localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [PROD_LO_W-1:0]    ROUND_HALF = PROD_LO_W'(1) << (FB - 1);

    // Window: [0],[1] current row, [2],[3] previous row, [4],[5] row before
    logic signed [SB-1:0] win_reg [6];

    // Stage 2: partial sums
    logic                    st2_valid_reg;
    fwr_pkg::ctrl_t          st2_ctrl_reg;
    logic signed [SB-1:0]    st2_copy_reg;
    logic signed [SUM_W-1:0] st2_a_reg, st2_b_reg, st2_c_reg;
    // Stage 3: stencil sum split for the multiply
    logic                    st3_valid_reg;
    fwr_pkg::ctrl_t          st3_ctrl_reg;
    logic signed [SB-1:0]    st3_copy_reg;
    logic signed [HI_W-1:0]  st3_hi_reg;
    logic [FB-1:0]           st3_lo_reg;
    // Stage 4: products
    logic                        st4_valid_reg;
    fwr_pkg::ctrl_t              st4_ctrl_reg;
    logic signed [SB-1:0]        st4_copy_reg;
    logic signed [PROD_HI_W-1:0] st4_prod_hi_reg;
    logic [PROD_LO_W-1:0]        st4_prod_lo_reg;
    // Stage 5: result word
    logic                    out_valid_reg;
    fwr_pkg::result_t        out_result_reg;

    logic signed [SUM_W-1:0]     part_a, part_b, part_c, sum;
    logic signed [EXT_W-1:0]     sum_ext;
    logic signed [PROD_HI_W-1:0] hi_ext, w_hi_ext;
    logic [PROD_LO_W-1:0]        lo_ext, w_lo_ext;
    logic [FRAC_W-1:0]           frac;
    logic signed [RES_W-1:0]     res;
    logic signed [SB-1:0]        sat_val, final_val;
    logic [VW-1:0]               final_word;

    // Window shift on every sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (in_valid) begin
            win_reg[1] <= win_reg[0];
            win_reg[0] <= in_cur;
            win_reg[3] <= win_reg[2];
            win_reg[2] <= in_prev;
            win_reg[5] <= win_reg[4];
            win_reg[4] <= in_prev2;
        end
    end

    // 1-2-1 / 2-4-2 / 1-2-1 in three partial sums
    always_comb begin
        part_a = (SUM_W'(win_reg[2]) <<< 2)
               + ((SUM_W'(win_reg[3]) + SUM_W'(in_prev)) <<< 1);
        part_b = ((SUM_W'(win_reg[4]) + SUM_W'(win_reg[0])) <<< 1)
               + SUM_W'(win_reg[5]) + SUM_W'(in_prev2);
        part_c = SUM_W'(win_reg[1]) + SUM_W'(in_cur);
    end

    assign sum     = st2_a_reg + st2_b_reg + st2_c_reg;
    assign sum_ext = EXT_W'(sum);

    assign hi_ext   = PROD_HI_W'(st3_hi_reg);
    assign w_hi_ext = PROD_HI_W'({1'b0, weight});
    assign lo_ext   = PROD_LO_W'(st3_lo_reg);
    assign w_lo_ext = PROD_LO_W'(weight);

    // Round half up, then clamp to the sample range
    always_comb begin
        frac = st4_prod_lo_reg[PROD_LO_W-1:FB];
        res  = RES_W'(st4_prod_hi_reg) + $signed(RES_W'(frac));
        if (res > SAT_HI) begin
            sat_val = SAT_HI[SB-1:0];
        end else if (res < SAT_LO) begin
            sat_val = SAT_LO[SB-1:0];
        end else begin
            sat_val = res[SB-1:0];
        end
        final_val = (st4_ctrl_reg.kind == fwr_pkg::KIND_INTERIOR) ? sat_val : st4_copy_reg;
    end

    // Fit the sample-width value to the output field
    generate
        if (SB >= VW) begin : g_trunc
            assign final_word = final_val[VW-1:0];
        end else begin : g_sext
            assign final_word = {{(VW - SB){final_val[SB-1]}}, final_val};
        end
    endgenerate

    // Pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st2_valid_reg <= in_valid && in_ctrl.emit;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            out_valid_reg <= st4_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        st2_ctrl_reg <= in_ctrl;
        st2_copy_reg <= (in_ctrl.kind == fwr_pkg::KIND_COPY_CUR) ? in_cur : in_prev;
        st2_a_reg    <= part_a;
        st2_b_reg    <= part_b;
        st2_c_reg    <= part_c;

        st3_ctrl_reg <= st2_ctrl_reg;
        st3_copy_reg <= st2_copy_reg;
        st3_hi_reg   <= sum_ext[EXT_W-1:FB];
        st3_lo_reg   <= sum_ext[FB-1:0];

        st4_ctrl_reg    <= st3_ctrl_reg;
        st4_copy_reg    <= st3_copy_reg;
        st4_prod_hi_reg <= hi_ext * w_hi_ext;
        st4_prod_lo_reg <= lo_ext * w_lo_ext + ROUND_HALF;

        out_result_reg.value <= final_word;
        out_result_reg.col   <= st4_ctrl_reg.col;
        out_result_reg.row   <= st4_ctrl_reg.row;
        out_result_reg.last  <= st4_ctrl_reg.last;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign pend_count = fwr_pkg::PEND_W'($countones({st2_valid_reg, st3_valid_reg,
                                                     st4_valid_reg, out_valid_reg}));

endmodule

[rtl/fwr_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwr_out_fifo
// Result queue that decouples the pipeline from output back-pressure.
// ----------------------------------------------------------------------------
module fwr_out_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  fwr_pkg::result_t                    push_data,
    input  logic                                pop,
    output logic                                out_valid,
    output fwr_pkg::result_t                    out_data,
    output logic [fwr_pkg::OUT_FIFO_CNT_W-1:0]  count
);

    fwr_pkg::result_t                    store_reg [fwr_pkg::OUT_FIFO_DEPTH];
    logic [fwr_pkg::OUT_FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [fwr_pkg::OUT_FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                                do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = store_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

[rtl/fwr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwr_checker
// Port-level checks on the restriction block, bound to its top level.
// ----------------------------------------------------------------------------
module fwr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [fwr_pkg::VALUE_W-1:0]         m_coarse_value,
    input logic [fwr_pkg::COARSE_COLS_W-1:0]   m_coarse_col,
    input logic [fwr_pkg::COARSE_ROWS_W-1:0]   m_coarse_row,
    input logic                                m_grid_last
);

    // A stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coarse_value)
            && $stable(m_coarse_col) && $stable(m_coarse_row) && $stable(m_grid_last))
        else $error("output word changed while stalled");

    // Line memories are being cleared after reset: no sample taken
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready straight after reset");

    // Reset empties the result queue
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid straight after reset");

    // The last point is the far corner, never on the first row or column
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grid_last |-> m_coarse_col != '0 && m_coarse_row != '0)
        else $error("grid end flagged on a first-row or first-column point");

endmodule

bind full_weighting_restriction_2d fwr_checker u_fwr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_coarse_value (m_coarse_value),
    .m_coarse_col   (m_coarse_col),
    .m_coarse_row   (m_coarse_row),
    .m_grid_last    (m_grid_last)
);
